### rtl/core/calendar_clock_tick_assert.svh
// Assertion macros shared by the calendar clock RTL.
// Each macro names the check, takes an antecedent and a consequent, and is
// sampled on the rising edge of clk with the checks held off during reset.
`ifndef CALENDAR_CLOCK_TICK_ASSERT_SVH
`define CALENDAR_CLOCK_TICK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/core/cct_pkg.sv
package cct_pkg;

  // Every cell in the chain holds one time field in a word of this width.
  localparam int WORD_W = 16;
  typedef logic [WORD_W-1:0] cell_word_t;

  // Position of each field in the chain, least significant first.
  localparam int IDX_SEC   = 0;
  localparam int IDX_MIN   = 1;
  localparam int IDX_HOUR  = 2;
  localparam int IDX_DAY   = 3;
  localparam int IDX_MONTH = 4;
  localparam int IDX_YEAR  = 5;
  localparam int NUM_CELLS = 6;

  // Item operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Roll-over thresholds: a field at or above its limit wraps on a carry.
  localparam cell_word_t SEC_LIMIT   = WORD_W'(59);
  localparam cell_word_t MIN_LIMIT   = WORD_W'(59);
  localparam cell_word_t HOUR_LIMIT  = WORD_W'(23);
  localparam cell_word_t MONTH_LIMIT = WORD_W'(12);
  localparam cell_word_t YEAR_LIMIT  = {WORD_W{1'b1}};

  // Values a field takes when it wraps.
  localparam cell_word_t WRAP_ZERO = WORD_W'(0);
  localparam cell_word_t WRAP_ONE  = WORD_W'(1);

  // Month numbers and lengths.
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [4:0] LEN_LONG  = 5'd31;
  localparam logic [4:0] LEN_SHORT = 5'd30;
  localparam logic [4:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [4:0] LEN_FEB   = 5'd28;

  // Divisibility by 25 on a 16-bit year: multiplying by the inverse of 25
  // modulo 2^16 maps exactly the multiples of 25 onto 0 .. 65535/25.
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

  // Control that every cell receives from the top level.
  typedef struct packed {
    logic load;  // item accepted carries new field values
    logic step;  // carry into this cell
  } cell_ctrl_t;

  // Gregorian rule: divisible by 4, and a multiple of 100 only if also a
  // multiple of 400 (400 = 16 * 25).
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Out-of-range months count as 31 days long.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [15:0] y);
    logic [4:0] len;
    case (m)
      MONTH_FEB: len = is_leap(y) ? LEN_FEB_LEAP : LEN_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/cct_cell.sv
// One field of the calendar: loads, counts on a carry in, and wraps once it
// has reached its limit, passing the carry to the next cell.
module cct_cell (
  input  logic               clk,
  input  logic               rst,
  input  cct_pkg::cell_ctrl_t ctrl,
  input  cct_pkg::cell_word_t load_val,
  input  cct_pkg::cell_word_t limit,
  input  cct_pkg::cell_word_t wrap_val,
  output cct_pkg::cell_word_t count,
  output logic               carry_out
);

  cct_pkg::cell_word_t count_next;
  logic                at_limit;

  assign at_limit  = (count >= limit);
  assign carry_out = ctrl.step && at_limit;

  always_comb begin
    count_next = count;
    if (ctrl.load) begin
      count_next = load_val;
    end else if (ctrl.step) begin
      count_next = at_limit ? wrap_val : count + cct_pkg::WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

### rtl/core/calendar_clock_tick.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------------
// input    | in_valid / in_ready   | op, set_second .. set_year
// output   | out_valid / out_ready | second .. year, indicator, minute_carry
//
// One beat is taken per clock cycle unless an untaken result blocks it;
// its result is registered. The ripple of carries through the six cells
// and the leap-year test (one 16 x 16 multiply) set the path into the registers.
// Synchronous active-high reset clears all fields to zero and the indicator off.
// A result that is not taken holds the next beat back, in_ready = !out_valid | out_ready.

`include "calendar_clock_tick_assert.svh"

module calendar_clock_tick (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [5:0]  set_second,
  input  logic [5:0]  set_minute,
  input  logic [4:0]  set_hour,
  input  logic [4:0]  set_date,
  input  logic [3:0]  set_month,
  input  logic [15:0] set_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  date,
  output logic [3:0]  month,
  output logic [15:0] year,
  output logic        indicator,
  output logic        minute_carry
);

  localparam int W = cct_pkg::WORD_W;

  // The cell registers are themselves the result register: the state only
  // moves when a beat is accepted, and a beat is accepted only when the
  // previous result leaves in the same cycle or has already left.
  logic                in_fire;
  logic                tick_fire;
  logic                load_fire;
  cct_pkg::cell_word_t load_val [cct_pkg::NUM_CELLS];
  cct_pkg::cell_word_t limit    [cct_pkg::NUM_CELLS];
  cct_pkg::cell_word_t wrap_val [cct_pkg::NUM_CELLS];
  cct_pkg::cell_word_t count    [cct_pkg::NUM_CELLS];
  cct_pkg::cell_ctrl_t ctrl     [cct_pkg::NUM_CELLS];
  logic [cct_pkg::NUM_CELLS:0] carry;
  logic [4:0]          day_len;
  logic                blink;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (op == cct_pkg::OP_TICK);
  assign load_fire = in_fire && (op == cct_pkg::OP_LOAD);

  // The length of the current month feeds the day cell's limit; a day at or
  // past the month end rolls to the first on the next day carry.
  assign day_len = cct_pkg::month_len(count[cct_pkg::IDX_MONTH][3:0],
                                      count[cct_pkg::IDX_YEAR][15:0]);

  assign load_val[cct_pkg::IDX_SEC]   = W'(set_second);
  assign load_val[cct_pkg::IDX_MIN]   = W'(set_minute);
  assign load_val[cct_pkg::IDX_HOUR]  = W'(set_hour);
  assign load_val[cct_pkg::IDX_DAY]   = W'(set_date);
  assign load_val[cct_pkg::IDX_MONTH] = W'(set_month);
  assign load_val[cct_pkg::IDX_YEAR]  = W'(set_year);

  assign limit[cct_pkg::IDX_SEC]   = cct_pkg::SEC_LIMIT;
  assign limit[cct_pkg::IDX_MIN]   = cct_pkg::MIN_LIMIT;
  assign limit[cct_pkg::IDX_HOUR]  = cct_pkg::HOUR_LIMIT;
  assign limit[cct_pkg::IDX_DAY]   = W'(day_len);
  assign limit[cct_pkg::IDX_MONTH] = cct_pkg::MONTH_LIMIT;
  assign limit[cct_pkg::IDX_YEAR]  = cct_pkg::YEAR_LIMIT;

  // Day and month restart at one; the others restart at zero.
  assign wrap_val[cct_pkg::IDX_SEC]   = cct_pkg::WRAP_ZERO;
  assign wrap_val[cct_pkg::IDX_MIN]   = cct_pkg::WRAP_ZERO;
  assign wrap_val[cct_pkg::IDX_HOUR]  = cct_pkg::WRAP_ZERO;
  assign wrap_val[cct_pkg::IDX_DAY]   = cct_pkg::WRAP_ONE;
  assign wrap_val[cct_pkg::IDX_MONTH] = cct_pkg::WRAP_ONE;
  assign wrap_val[cct_pkg::IDX_YEAR]  = cct_pkg::WRAP_ZERO;

  // A tick is the carry into the seconds cell; each cell passes its carry on.
  // The year cell's carry out only marks the wrap and is not needed further.
  assign carry[0] = tick_fire;

  for (genvar i = 0; i < cct_pkg::NUM_CELLS; i++) begin : g_cell
    assign ctrl[i].load = load_fire;
    assign ctrl[i].step = carry[i];

    cct_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[i]),
      .load_val  (load_val[i]),
      .limit     (limit[i]),
      .wrap_val  (wrap_val[i]),
      .count     (count[i]),
      .carry_out (carry[i+1])
    );
  end

  // Indicator toggles on every tick; the minute pulse belongs to the beat
  // that produced it and is cleared by a load.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      blink        <= 1'b0;
      minute_carry <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid    <= 1'b1;
        minute_carry <= carry[cct_pkg::IDX_SEC + 1];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (tick_fire) begin
        blink <= !blink;
      end
    end
  end

  assign second    = count[cct_pkg::IDX_SEC][5:0];
  assign minute    = count[cct_pkg::IDX_MIN][5:0];
  assign hour      = count[cct_pkg::IDX_HOUR][4:0];
  assign date      = count[cct_pkg::IDX_DAY][4:0];
  assign month     = count[cct_pkg::IDX_MONTH][3:0];
  assign year      = count[cct_pkg::IDX_YEAR][15:0];
  assign indicator = blink;

  `CCT_ASSERT_SAME(a_carry_zero_sec, out_valid && minute_carry, second == 6'd0)
  `CCT_ASSERT_NEXT(a_load_sec, load_fire, (second == $past(set_second)) && !minute_carry)
  `CCT_ASSERT_NEXT(a_load_year, load_fire, year == $past(set_year))
  `CCT_ASSERT_NEXT(a_tick_blink, tick_fire, indicator != $past(indicator))
  `CCT_ASSERT_NEXT(a_idle_hold, !in_fire, $stable(second) && $stable(year) && $stable(indicator))

endmodule

### verif/tb_calendar_clock_tick.sv
// Self-checking bench for the calendar clock.
//
// Beats are offered on the input channel and the results are taken on the
// output channel, both through valid/ready. Every accepted input beat is run
// through a behavioural model of the calendar that is kept inside this bench,
// and the reading that the model predicts, or for a typed directed row the
// reading given in the table, is queued. Each result beat that the block hands
// over is then compared field by field with the oldest queued reading.
//
// The stimulus opens with a short table of directed beats. It covers the
// state after reset, the widest field values, every roll-over, a day of zero,
// months of zero and above twelve, and the leap-year rule for century and
// ordinary years. A random part follows. Most of it loads a time just short of
// a roll-over and then ticks through it, so that the carries into the day,
// month and year are exercised often. The rest is noise: loads of arbitrary
// bit patterns and runs of plain ticks.
//
// Inputs change on the falling edge of the clock and everything is sampled on
// the rising edge, so no check depends on the order of events within a step.
module tb_calendar_clock_tick;

  localparam int unsigned RANDOM_BEATS   = 750;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned PRESSURE_AT    = 400;   // readings taken before the long hold
  localparam int unsigned PRESSURE_HOLD  = 300;   // cycles the receiver refuses beats
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One input beat: an operation and the six time fields that a load takes.
  typedef struct packed {
    logic        op;
    logic [5:0]  sec;
    logic [5:0]  mins;
    logic [4:0]  hrs;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [15:0] yr;
  } beat_t;

  // One result beat: the time after the item, the indicator and the carry.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  date;
    logic [3:0]  month;
    logic [15:0] year;
    logic        indicator;
    logic        minute_carry;
  } reading_t;

  // The calendar as the bench believes it stands.
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  mins;
    logic [4:0]  hrs;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [15:0] yr;
    logic        blink;
  } calendar_t;

  // A row of the directed table. Where typed is set, want holds a reading
  // that is obvious from the stimulus and is checked in place of the model.
  typedef struct {
    beat_t    beat;
    bit       typed;
    reading_t want;
  } table_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [5:0]  set_second;
  logic [5:0]  set_minute;
  logic [4:0]  set_hour;
  logic [4:0]  set_date;
  logic [3:0]  set_month;
  logic [15:0] set_year;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  date;
  logic [3:0]  month;
  logic [15:0] year;
  logic        indicator;
  logic        minute_carry;

  calendar_t   cal_now;
  reading_t    pending_readings[$];
  int unsigned beats_sent;
  int unsigned readings_taken;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          pressure_done;

  calendar_clock_tick i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .set_second   (set_second),
    .set_minute   (set_minute),
    .set_hour     (set_hour),
    .set_date     (set_date),
    .set_month    (set_month),
    .set_year     (set_year),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .date         (date),
    .month        (month),
    .year         (year),
    .indicator    (indicator),
    .minute_carry (minute_carry)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year, but a century only when it is also a
  // multiple of four hundred.
  function automatic bit leap_year(input logic [15:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Months outside one to twelve are taken to be 31 days long.
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [15:0] y);
    logic [4:0] len;
    case (m)
      4'd2:                   len = leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // Applies one accepted beat to the model and returns the reading that the
  // block should report for it. Comparisons against the limits use "at or
  // above" so that fields loaded out of range still roll over on the next
  // carry into them.
  function automatic reading_t advance_calendar(input beat_t b);
    reading_t r;
    r.minute_carry = 1'b0;
    if (b.op == cct_pkg::OP_LOAD) begin
      // A load takes the fields as they are and leaves the indicator alone.
      cal_now.sec  = b.sec;
      cal_now.mins = b.mins;
      cal_now.hrs  = b.hrs;
      cal_now.day  = b.day;
      cal_now.mon  = b.mon;
      cal_now.yr   = b.yr;
    end else begin
      cal_now.blink = ~cal_now.blink;
      if (cal_now.sec >= 6'd59) begin
        cal_now.sec    = '0;
        r.minute_carry = 1'b1;
        if (cal_now.mins >= 6'd59) begin
          cal_now.mins = '0;
          if (cal_now.hrs >= 5'd23) begin
            cal_now.hrs = '0;
            // Day carry. The sum is formed wide so that a day of 31 cannot
            // wrap before it is compared with the month length.
            if (int'(cal_now.day) + 1 > int'(days_in_month(cal_now.mon, cal_now.yr))) begin
              cal_now.day = 5'd1;
              if (cal_now.mon >= 4'd12) begin
                cal_now.mon = 4'd1;
                cal_now.yr  = cal_now.yr + 16'd1;
              end else begin
                cal_now.mon = cal_now.mon + 4'd1;
              end
            end else begin
              cal_now.day = cal_now.day + 5'd1;
            end
          end else begin
            cal_now.hrs = cal_now.hrs + 5'd1;
          end
        end else begin
          cal_now.mins = cal_now.mins + 6'd1;
        end
      end else begin
        cal_now.sec = cal_now.sec + 6'd1;
      end
    end
    r.second    = cal_now.sec;
    r.minute    = cal_now.mins;
    r.hour      = cal_now.hrs;
    r.date      = cal_now.day;
    r.month     = cal_now.mon;
    r.year      = cal_now.yr;
    r.indicator = cal_now.blink;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A tick carries random load fields, which the block has to ignore.
  function automatic beat_t tick_beat();
    beat_t b;
    b = beat_t'({$urandom, $urandom});
    b.op = cct_pkg::OP_TICK;
    return b;
  endfunction

  function automatic beat_t load_beat(input int s, input int mi, input int h, input int d,
                                      input int mo, input int y);
    beat_t b;
    b.op   = cct_pkg::OP_LOAD;
    b.sec  = 6'(s);
    b.mins = 6'(mi);
    b.hrs  = 5'(h);
    b.day  = 5'(d);
    b.mon  = 4'(mo);
    b.yr   = 16'(y);
    return b;
  endfunction

  function automatic reading_t reading(input int s, input int mi, input int h, input int d,
                                       input int mo, input int y, input bit ind,
                                       input bit carry);
    reading_t r;
    r.second       = 6'(s);
    r.minute       = 6'(mi);
    r.hour         = 5'(h);
    r.date         = 5'(d);
    r.month        = 4'(mo);
    r.year         = 16'(y);
    r.indicator    = ind;
    r.minute_carry = carry;
    return r;
  endfunction

  function automatic table_row_t row(input beat_t b, input bit typed = 1'b0,
                                     input reading_t want = '0);
    table_row_t t;
    t.beat  = b;
    t.typed = typed;
    t.want  = want;
    return t;
  endfunction

  // Years are biased towards the interesting cases of the leap rule and the
  // top of the 16-bit range.
  function automatic logic [15:0] pick_year();
    logic [15:0] y;
    case ($urandom_range(0, 4))
      0:       y = 16'($urandom_range(0, 163) * 400);
      1:       y = 16'($urandom_range(0, 655) * 100);
      2:       y = 16'($urandom_range(0, 16383) * 4);
      3:       y = 16'hFFFF;
      default: y = 16'($urandom);
    endcase
    return y;
  endfunction

  // A load that sits a few seconds before a roll-over, usually on the last day
  // of its month or the one before, so that a short burst of ticks reaches
  // the day, month and year carries.
  function automatic beat_t rollover_load();
    beat_t b;
    b      = tick_beat();
    b.op   = cct_pkg::OP_LOAD;
    b.sec  = 6'($urandom_range(55, 59));
    b.mins = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 59)) : 6'd59;
    b.hrs  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 23)) : 5'd23;
    b.mon  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 12));
    b.yr   = pick_year();
    b.day  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                          : days_in_month(b.mon, b.yr) - 5'($urandom_range(0, 1));
    return b;
  endfunction

  // Offers one beat on the input channel. It is entered on a falling edge
  // and returns on the falling edge after the beat was taken, so that valid
  // either stays high for the next beat or is lowered, but never both in one
  // step. Runs of beats are sent with no gap so that back-to-back traffic is
  // seen as well as sparse traffic.
  task automatic offer_beat(input beat_t b, input bit typed, input reading_t want);
    int unsigned gap;
    reading_t    predicted;
    gap = ((beats_sent / 32) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= b.op;
    set_second <= b.sec;
    set_minute <= b.mins;
    set_hour   <= b.hrs;
    set_date   <= b.day;
    set_month  <= b.mon;
    set_year   <= b.yr;
    do @(posedge clk); while (!in_ready);
    predicted = advance_calendar(b);
    pending_readings.push_back(typed ? want : predicted);
    beats_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    table_row_t  rows[$];
    beat_t       b;
    int unsigned burst;

    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = cct_pkg::OP_TICK;
    set_second = '0;
    set_minute = '0;
    set_hour   = '0;
    set_date   = '0;
    set_month  = '0;
    set_year   = '0;
    cal_now    = '0;

    // Directed table. The first rows carry their reading, since it can be
    // seen from the stimulus; the rest are checked against the model.
    // First tick after reset: only the seconds move and the indicator comes on.
    rows.push_back(row(tick_beat(), 1, reading(1, 0, 0, 0, 0, 0, 1, 0)));
    // Last second of the year at the top of the year range: every field wraps.
    rows.push_back(row(load_beat(59, 59, 23, 31, 12, 65535), 1,
                       reading(59, 59, 23, 31, 12, 65535, 1, 0)));
    rows.push_back(row(tick_beat(), 1, reading(0, 0, 0, 1, 1, 0, 0, 1)));
    // Every field at the top of its bit width.
    rows.push_back(row(load_beat(63, 63, 31, 31, 15, 65535), 1,
                       reading(63, 63, 31, 31, 15, 65535, 0, 0)));
    rows.push_back(row(tick_beat(), 1, reading(0, 0, 0, 1, 1, 0, 1, 1)));
    // Every field cleared.
    rows.push_back(row(load_beat(0, 0, 0, 0, 0, 0), 1, reading(0, 0, 0, 0, 0, 0, 1, 0)));
    rows.push_back(row(tick_beat(), 1, reading(1, 0, 0, 0, 0, 0, 0, 0)));
    // Day zero in month zero: the day carry only brings the day to one.
    rows.push_back(row(load_beat(59, 59, 23, 0, 0, 100)));
    rows.push_back(row(tick_beat()));
    // Month zero running out after 31 days.
    rows.push_back(row(load_beat(59, 59, 23, 31, 0, 7)));
    rows.push_back(row(tick_beat()));
    // February in a year divisible by four hundred has 29 days.
    rows.push_back(row(load_beat(59, 59, 23, 28, 2, 2000)));
    rows.push_back(row(tick_beat()));
    // A century year that is not divisible by four hundred is not a leap year.
    rows.push_back(row(load_beat(59, 59, 23, 28, 2, 1900)));
    rows.push_back(row(tick_beat()));
    // An ordinary year that is not divisible by four.
    rows.push_back(row(load_beat(59, 59, 23, 28, 2, 2023)));
    rows.push_back(row(tick_beat()));
    // End of a thirty-day month.
    rows.push_back(row(load_beat(59, 59, 23, 30, 4, 2024)));
    rows.push_back(row(tick_beat()));
    // A month above twelve ends like December.
    rows.push_back(row(load_beat(59, 59, 23, 31, 13, 41)));
    rows.push_back(row(tick_beat()));
    // A minute carry that stops at the minutes.
    rows.push_back(row(load_beat(59, 10, 5, 15, 6, 1999)));
    rows.push_back(row(tick_beat()));
    // A plain second that stops just short of an hour carry.
    rows.push_back(row(load_beat(58, 59, 22, 30, 11, 2024)));
    rows.push_back(row(tick_beat()));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) offer_beat(rows[i].beat, rows[i].typed, rows[i].want);

    // Random part: mostly a load just before a roll-over followed by a short
    // burst of ticks; now and then a load of arbitrary bits or a long run of
    // ticks from wherever the calendar happens to stand.
    while (beats_sent < RANDOM_BEATS + rows.size()) begin
      case ($urandom_range(0, 9))
        0: begin
          b    = beat_t'({$urandom, $urandom});
          b.op = cct_pkg::OP_LOAD;
          burst = $urandom_range(0, 3);
        end
        1: begin
          b     = tick_beat();
          burst = $urandom_range(0, 20);
        end
        default: begin
          b     = rollover_load();
          burst = $urandom_range(1, 6);
        end
      endcase
      offer_beat(b, 1'b0, '0);
      repeat (burst) offer_beat(tick_beat(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Wait for every outstanding reading, then give the block a few more
    // cycles in which any stray result beat would be caught.
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------

  // Draws a stall before each result beat. Every so often it takes a run of
  // beats with no stall at all, and once, part way through, it refuses beats
  // for a long stretch so that the output register fills and in_ready drops
  // while the sender keeps offering.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (readings_taken >= PRESSURE_AT && !pressure_done) begin
        stall         = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end else if ((readings_taken / 32) % 4 == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s mismatch on reading %0d: expected %0d, got %0d",
               $time, field, readings_taken, want, got);
  endtask

  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: result beat with no reading outstanding", $time);
    end else begin
      want = pending_readings.pop_front();
      if (second !== want.second)             note_mismatch("second", want.second, second);
      if (minute !== want.minute)             note_mismatch("minute", want.minute, minute);
      if (hour !== want.hour)                 note_mismatch("hour", want.hour, hour);
      if (date !== want.date)                 note_mismatch("date", want.date, date);
      if (month !== want.month)               note_mismatch("month", want.month, month);
      if (year !== want.year)                 note_mismatch("year", want.year, year);
      if (indicator !== want.indicator)       note_mismatch("indicator", want.indicator,
                                                            indicator);
      if (minute_carry !== want.minute_carry) note_mismatch("minute_carry",
                                                            want.minute_carry, minute_carry);
    end
    readings_taken++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_reading();
  end

  // Watchdog: a run of cycles in which no beat moves on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
